// File: hdl/json_string_unescape_utf8_core_defines.svh
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared concurrent assertion helpers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define JSU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JSU_ASSERT_IMP(label, ante, cons, msg)
`define JSU_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Phase and result codes, character constants and small decode functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_BODY    = 3'd1,
        PH_ESC     = 3'd2,
        PH_HEX     = 3'd3,
        PH_WANT_BS = 3'd4,
        PH_WANT_U  = 3'd5,
        PH_LOWHEX  = 3'd6
    } t_phase;

    // Error codes reported in a result.
    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_CONTROL      = 4'd1,
        ERR_BAD_ESCAPE   = 4'd2,
        ERR_BAD_HEX      = 4'd3,
        ERR_MISSING_LOW  = 4'd4,
        ERR_BAD_LOW      = 4'd5,
        ERR_LONE_LOW     = 4'd6,
        ERR_NO_QUOTE     = 4'd7,
        ERR_UNTERMINATED = 4'd8,
        ERR_CUT_ESCAPE   = 4'd9,
        ERR_SHORT_HEX    = 4'd10
    } t_err;

    // Kind of a buffered result.
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // A UTF-8 run: up to four bytes, first byte at index 0.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_utf8;

    localparam logic [7:0]  CH_QUOTE   = 8'h22;
    localparam logic [7:0]  CH_BSLASH  = 8'h5C;
    localparam logic [7:0]  CH_SLASH   = 8'h2F;
    localparam logic [7:0]  CH_U       = 8'h75;
    localparam logic [7:0]  CH_CTRL_LIM = 8'h20;
    localparam logic [15:0] SURR_HI_LO = 16'hD800;
    localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
    localparam logic [15:0] SURR_LO_LO = 16'hDC00;
    localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    // Hex digit value; bit 4 set when the byte is a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // UTF-8 encoding of a code point up to 0x10FFFF.
    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 r;
        r.bytes    = '0;
        r.last_idx = 2'd0;
        if (cp <= 21'h7F) begin
            r.bytes[0] = {1'b0, cp[6:0]};
            r.last_idx = 2'd0;
        end else if (cp <= 21'h7FF) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.last_idx = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.last_idx = 2'd2;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

endpackage

// File: hdl/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// JSON string unescaper with UTF-8 output
// Streams text bytes, decodes one quoted JSON string at a time and emits the
// decoded UTF-8 bytes, a done mark at the closing quote, or an error code.
// ----------------------------------------------------------------------------
// Each transaction on the input carries one text byte or an end-of-text mark.
// It is registered, decoded combinationally against the parser state and, if it
// produces anything, loaded into a result buffer that holds one run of up to
// four results. The buffer drains one result per cycle on the output while
// i_out_ready is high, so plain text streams at one byte per clock when the
// output does not stall; an escape that completes a code point of more than one
// UTF-8 byte holds the next input in the input register while the buffer drains.
// The last result of each run is flagged with o_last.
`include "json_string_unescape_utf8_core_defines.svh"

module json_string_unescape_utf8_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    // Output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_string_done,
    output logic [3:0] o_error_code,
    output logic       o_last
);
    import jsu_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eot;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [1:0]  r_digits, n_digits;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_hs, n_hs;

    // Result buffer
    logic            r_run_valid;
    t_kind           r_run_kind;
    t_err            r_run_err;
    logic [3:0][7:0] r_run_bytes;
    logic [1:0]      r_run_last;
    logic [1:0]      r_run_idx;

    // Decode results for the registered item
    logic            w_res_has;
    t_kind           w_res_kind;
    t_err            w_res_err;
    logic [3:0][7:0] w_res_bytes;
    logic [1:0]      w_res_last;

    logic        w_out_take;
    logic        w_buf_free;
    logic        w_fire;
    logic [4:0]  w_hex;
    logic [15:0] w_acc_next;
    logic        w_is_high;
    logic        w_is_low;
    logic [20:0] w_cp;
    t_utf8       w_enc;

    // Handshake: decode fires when the buffer is empty or its last result leaves.
    assign w_out_take = r_run_valid && i_out_ready;
    assign w_buf_free = !r_run_valid || (w_out_take && (r_run_idx == r_run_last));
    assign w_fire     = r_in_valid && w_buf_free;
    assign o_in_ready = !r_in_valid || w_fire;

    // Shared decode terms.
    assign w_hex      = hex_value(r_in_byte);
    assign w_acc_next = {r_acc[11:0], w_hex[3:0]};
    assign w_is_high  = (w_acc_next >= SURR_HI_LO) && (w_acc_next <= SURR_HI_HI);
    assign w_is_low   = (w_acc_next >= SURR_LO_LO) && (w_acc_next <= SURR_LO_HI);
    assign w_cp       = (r_phase == PH_LOWHEX)
                        ? SUPP_BASE + {1'b0, r_hs, w_acc_next[9:0]}
                        : {5'd0, w_acc_next};
    assign w_enc      = utf8_encode(w_cp);

    // Next parser state.
    always_comb begin
        n_phase  = r_phase;
        n_digits = r_digits;
        n_acc    = r_acc;
        n_hs     = r_hs;
        case (r_phase)
            PH_IDLE: begin
                if (!r_in_eot && r_in_byte == CH_QUOTE) begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_in_eot || r_in_byte == CH_QUOTE || r_in_byte < CH_CTRL_LIM) begin
                    n_phase = PH_IDLE;
                end else if (r_in_byte == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end
            end
            PH_ESC: begin
                n_phase = PH_IDLE;
                if (!r_in_eot) begin
                    case (r_in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH,
                        8'h62, 8'h66, 8'h6E, 8'h72, 8'h74: begin
                            n_phase = PH_BODY;
                        end
                        CH_U: begin
                            n_phase  = PH_HEX;
                            n_digits = 2'd0;
                            n_acc    = 16'd0;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_WANT_BS: begin
                n_phase = (!r_in_eot && r_in_byte == CH_BSLASH) ? PH_WANT_U : PH_IDLE;
            end
            PH_WANT_U: begin
                if (!r_in_eot && r_in_byte == CH_U) begin
                    n_phase  = PH_LOWHEX;
                    n_digits = 2'd0;
                    n_acc    = 16'd0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_HEX, PH_LOWHEX: begin
                if (r_in_eot || !w_hex[4]) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_acc = w_acc_next;
                    if (r_digits != 2'd3) begin
                        n_digits = r_digits + 2'd1;
                    end else begin
                        n_digits = 2'd0;
                        if (r_phase == PH_LOWHEX) begin
                            n_phase = w_is_low ? PH_BODY : PH_IDLE;
                        end else if (w_is_high) begin
                            n_hs    = w_acc_next[9:0];
                            n_phase = PH_WANT_BS;
                        end else if (w_is_low) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Results produced by the registered item.
    always_comb begin
        w_res_has   = 1'b0;
        w_res_kind  = KIND_BYTE;
        w_res_err   = ERR_NONE;
        w_res_bytes = '0;
        w_res_last  = 2'd0;
        case (r_phase)
            PH_IDLE: begin
                if (!r_in_eot && r_in_byte != CH_QUOTE) begin
                    w_res_has  = 1'b1;
                    w_res_kind = KIND_ERROR;
                    w_res_err  = ERR_NO_QUOTE;
                end
            end
            PH_BODY: begin
                w_res_has = 1'b1;
                if (r_in_eot) begin
                    w_res_kind = KIND_ERROR;
                    w_res_err  = ERR_UNTERMINATED;
                end else if (r_in_byte == CH_QUOTE) begin
                    w_res_kind = KIND_DONE;
                end else if (r_in_byte == CH_BSLASH) begin
                    w_res_has = 1'b0;
                end else if (r_in_byte < CH_CTRL_LIM) begin
                    w_res_kind = KIND_ERROR;
                    w_res_err  = ERR_CONTROL;
                end else begin
                    w_res_bytes[0] = r_in_byte;
                end
            end
            PH_ESC: begin
                w_res_has = 1'b1;
                if (r_in_eot) begin
                    w_res_kind = KIND_ERROR;
                    w_res_err  = ERR_CUT_ESCAPE;
                end else begin
                    case (r_in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: w_res_bytes[0] = r_in_byte;
                        8'h62:   w_res_bytes[0] = 8'h08;
                        8'h66:   w_res_bytes[0] = 8'h0C;
                        8'h6E:   w_res_bytes[0] = 8'h0A;
                        8'h72:   w_res_bytes[0] = 8'h0D;
                        8'h74:   w_res_bytes[0] = 8'h09;
                        CH_U:    w_res_has = 1'b0;
                        default: begin
                            w_res_kind = KIND_ERROR;
                            w_res_err  = ERR_BAD_ESCAPE;
                        end
                    endcase
                end
            end
            PH_WANT_BS: begin
                if (r_in_eot || r_in_byte != CH_BSLASH) begin
                    w_res_has  = 1'b1;
                    w_res_kind = KIND_ERROR;
                    w_res_err  = ERR_MISSING_LOW;
                end
            end
            PH_WANT_U: begin
                if (r_in_eot || r_in_byte != CH_U) begin
                    w_res_has  = 1'b1;
                    w_res_kind = KIND_ERROR;
                    w_res_err  = ERR_MISSING_LOW;
                end
            end
            PH_HEX, PH_LOWHEX: begin
                if (r_in_eot) begin
                    w_res_has  = 1'b1;
                    w_res_kind = KIND_ERROR;
                    w_res_err  = (r_phase == PH_HEX) ? ERR_SHORT_HEX : ERR_MISSING_LOW;
                end else if (!w_hex[4]) begin
                    w_res_has  = 1'b1;
                    w_res_kind = KIND_ERROR;
                    w_res_err  = ERR_BAD_HEX;
                end else if (r_digits == 2'd3) begin
                    if (r_phase == PH_LOWHEX && !w_is_low) begin
                        w_res_has  = 1'b1;
                        w_res_kind = KIND_ERROR;
                        w_res_err  = ERR_BAD_LOW;
                    end else if (r_phase == PH_HEX && w_is_low) begin
                        w_res_has  = 1'b1;
                        w_res_kind = KIND_ERROR;
                        w_res_err  = ERR_LONE_LOW;
                    end else if (r_phase == PH_LOWHEX || !w_is_high) begin
                        w_res_has   = 1'b1;
                        w_res_bytes = w_enc.bytes;
                        w_res_last  = w_enc.last_idx;
                    end
                end
            end
            default: begin
                w_res_has = 1'b0;
            end
        endcase
    end

    // Input register: holds one transaction until it is decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    // Parser state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_digits <= 2'd0;
            r_acc    <= 16'd0;
            r_hs     <= 10'd0;
        end else if (w_fire) begin
            r_phase  <= n_phase;
            r_digits <= n_digits;
            r_acc    <= n_acc;
            r_hs     <= n_hs;
        end
    end

    // Result buffer: load a run on decode, step through it as results leave.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_run_idx   <= 2'd0;
        end else if (w_fire && w_res_has) begin
            r_run_valid <= 1'b1;
            r_run_idx   <= 2'd0;
        end else if (w_out_take) begin
            if (r_run_idx == r_run_last) begin
                r_run_valid <= 1'b0;
            end else begin
                r_run_idx <= r_run_idx + 2'd1;
            end
        end
        if (w_fire && w_res_has) begin
            r_run_kind  <= w_res_kind;
            r_run_err   <= w_res_err;
            r_run_bytes <= w_res_bytes;
            r_run_last  <= w_res_last;
        end
    end

    // Output fields from the buffer.
    assign o_out_valid   = r_run_valid;
    assign o_out_byte    = (r_run_kind == KIND_BYTE) ? r_run_bytes[r_run_idx] : 8'd0;
    assign o_byte_valid  = (r_run_kind == KIND_BYTE);
    assign o_string_done = (r_run_kind == KIND_DONE);
    assign o_error_code  = (r_run_kind == KIND_ERROR) ? r_run_err : ERR_NONE;
    assign o_last        = (r_run_idx == r_run_last);

    // Checks on the decode and buffer logic.
    `JSU_ASSERT_IMP(a_byte_clean, o_out_valid && o_byte_valid, o_error_code == ERR_NONE && !o_string_done, "byte result carries a done mark or error")
    `JSU_ASSERT_IMP(a_mark_single, o_out_valid && !o_byte_valid, o_last, "done or error result is not alone in its run")
    `JSU_ASSERT_IMP(a_idx_range, r_run_valid, r_run_idx <= r_run_last, "result index ran past the run")
    `JSU_ASSERT_NXT(a_idx_step, w_out_take && !o_last, r_run_valid && r_run_idx == $past(r_run_idx) + 2'd1, "run did not advance")
    `JSU_ASSERT_NXT(a_err_idle, w_fire && w_res_has && w_res_kind == KIND_ERROR, r_phase == PH_IDLE, "parser did not return to idle after an error")

endmodule

// File: tb/sv/tb_json_string_unescape_utf8_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Sends quoted text one byte per transaction through directed and random
// tests. A behavioral decoder predicts the UTF-8 bytes, done marks and
// error codes, and each result is checked field by field as it leaves.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_core;

    import jsu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;

    // One expected result of the decoder.
    typedef struct packed {
        logic [7:0] data;
        logic       bval;
        logic       done;
        t_err       err;
        logic       last;
    } t_decoded;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_text_byte   = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_string_done;
    logic [3:0] o_error_code;
    logic       o_last;

    // Decoder state of the prediction.
    t_phase      dec_phase = PH_IDLE;
    logic [1:0]  dec_ndig  = 2'd0;
    logic [15:0] dec_acc   = 16'd0;
    logic [9:0]  dec_hi    = 10'd0;
    int          new_results;

    t_decoded decoded_q[$];
    int       fail_count   = 0;
    int       items_sent   = 0;
    int       stall_cycles = 0;
    bit       idle_en      = 1'b1;
    bit       rx_hold_req  = 1'b0;

    json_string_unescape_utf8_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_string_done (o_string_done),
        .o_error_code  (o_error_code),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Value of a hex digit, or -1 for any other byte.
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    task automatic add_result(input logic [7:0] b, input logic bv, input logic dn,
                              input t_err e);
        t_decoded r;
        r.data = b;
        r.bval = bv;
        r.done = dn;
        r.err  = e;
        r.last = 1'b0;
        decoded_q = {decoded_q, r};
        new_results++;
    endtask

    task automatic flag_error(input t_err e);
        dec_phase = PH_IDLE;
        add_result(8'h00, 1'b0, 1'b0, e);
    endtask

    // Splits a code point into its UTF-8 run.
    task automatic add_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_result(cp[7:0], 1'b1, 1'b0, ERR_NONE);
        end else if (cp < 21'h800) begin
            add_result(8'hC0 | cp[10:6], 1'b1, 1'b0, ERR_NONE);
            add_result(8'h80 | cp[5:0], 1'b1, 1'b0, ERR_NONE);
        end else if (cp < 21'h10000) begin
            add_result(8'hE0 | cp[15:12], 1'b1, 1'b0, ERR_NONE);
            add_result(8'h80 | cp[11:6], 1'b1, 1'b0, ERR_NONE);
            add_result(8'h80 | cp[5:0], 1'b1, 1'b0, ERR_NONE);
        end else begin
            add_result(8'hF0 | cp[20:18], 1'b1, 1'b0, ERR_NONE);
            add_result(8'h80 | cp[17:12], 1'b1, 1'b0, ERR_NONE);
            add_result(8'h80 | cp[11:6], 1'b1, 1'b0, ERR_NONE);
            add_result(8'h80 | cp[5:0], 1'b1, 1'b0, ERR_NONE);
        end
    endtask

    // Advances the decoder by one accepted transaction and queues its results.
    task automatic predict_unescape(input logic [7:0] c, input logic eot);
        int          d;
        logic [15:0] v;
        new_results = 0;
        case (dec_phase)
            PH_IDLE: begin
                if (!eot) begin
                    if (c == CH_QUOTE) dec_phase = PH_BODY;
                    else flag_error(ERR_NO_QUOTE);
                end
            end
            PH_BODY: begin
                if (eot) begin
                    flag_error(ERR_UNTERMINATED);
                end else if (c == CH_QUOTE) begin
                    dec_phase = PH_IDLE;
                    add_result(8'h00, 1'b0, 1'b1, ERR_NONE);
                end else if (c == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                end else if (c < CH_CTRL_LIM) begin
                    flag_error(ERR_CONTROL);
                end else begin
                    add_result(c, 1'b1, 1'b0, ERR_NONE);
                end
            end
            PH_ESC: begin
                if (eot) begin
                    flag_error(ERR_CUT_ESCAPE);
                end else begin
                    dec_phase = PH_BODY;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(c, 1'b1, 1'b0, ERR_NONE);
                        "b":  add_result(8'h08, 1'b1, 1'b0, ERR_NONE);
                        "f":  add_result(8'h0C, 1'b1, 1'b0, ERR_NONE);
                        "n":  add_result(8'h0A, 1'b1, 1'b0, ERR_NONE);
                        "r":  add_result(8'h0D, 1'b1, 1'b0, ERR_NONE);
                        "t":  add_result(8'h09, 1'b1, 1'b0, ERR_NONE);
                        CH_U: begin
                            dec_phase = PH_HEX;
                            dec_ndig  = 2'd0;
                            dec_acc   = 16'd0;
                        end
                        default: flag_error(ERR_BAD_ESCAPE);
                    endcase
                end
            end
            PH_WANT_BS: begin
                if (eot || c != CH_BSLASH) flag_error(ERR_MISSING_LOW);
                else dec_phase = PH_WANT_U;
            end
            PH_WANT_U: begin
                if (eot || c != CH_U) begin
                    flag_error(ERR_MISSING_LOW);
                end else begin
                    dec_phase = PH_LOWHEX;
                    dec_ndig  = 2'd0;
                    dec_acc   = 16'd0;
                end
            end
            PH_HEX, PH_LOWHEX: begin
                d = hex_digit(c);
                if (eot) begin
                    if (dec_phase == PH_HEX) flag_error(ERR_SHORT_HEX);
                    else flag_error(ERR_MISSING_LOW);
                end else if (d < 0) begin
                    flag_error(ERR_BAD_HEX);
                end else begin
                    dec_acc = {dec_acc[11:0], d[3:0]};
                    if (dec_ndig != 2'd3) begin
                        dec_ndig = dec_ndig + 2'd1;
                    end else begin
                        dec_ndig = 2'd0;
                        v        = dec_acc;
                        if (dec_phase == PH_LOWHEX) begin
                            // Second half of a pair must be a low surrogate.
                            if (v < SURR_LO_LO || v > SURR_LO_HI) begin
                                flag_error(ERR_BAD_LOW);
                            end else begin
                                dec_phase = PH_BODY;
                                add_code_point(SUPP_BASE + {dec_hi, 10'd0}
                                               + (v - SURR_LO_LO));
                            end
                        end else if (v >= SURR_HI_LO && v <= SURR_HI_HI) begin
                            dec_hi    = v[9:0];
                            dec_phase = PH_WANT_BS;
                        end else if (v >= SURR_LO_LO && v <= SURR_LO_HI) begin
                            flag_error(ERR_LONE_LOW);
                        end else begin
                            dec_phase = PH_BODY;
                            add_code_point({5'd0, v});
                        end
                    end
                end
            end
            default: dec_phase = PH_IDLE;
        endcase
        // Flag the final result of this transaction's run.
        if (new_results > 0) begin
            decoded_q[decoded_q.size() - 1].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Input transactions feed the prediction before any result is checked.
    always @(posedge i_clk) begin : scoreboard
        t_decoded want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) predict_unescape(i_text_byte, i_end_of_text);
            if (o_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual byte 0x%0h %s",
                             $time, o_out_byte,
                             $sformatf("valid %0b done %0b error %0d last %0b",
                                       o_byte_valid, o_string_done, o_error_code, o_last));
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", want.data, o_out_byte);
                    check_field("byte_valid", {7'd0, want.bval}, {7'd0, o_byte_valid});
                    check_field("string_done", {7'd0, want.done}, {7'd0, o_string_done});
                    check_field("error_code", {4'd0, want.err}, {4'd0, o_error_code});
                    check_field("last", {7'd0, want.last}, {7'd0, o_last});
                end
            end
        end
    end

    // Ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, decoded_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
                rx_hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one text transaction and waits until it is accepted.
    task automatic send_char(input logic [7:0] b, input logic eot);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // The byte field carries noise when the text ends.
    task automatic send_eot();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    task automatic send_hex16(input logic [15:0] v);
        for (int i = 3; i >= 0; i--) send_char(hex_char(v[4*i +: 4]), 1'b0);
    endtask

    task automatic send_u_escape(input logic [15:0] v);
        send_char(CH_BSLASH, 1'b0);
        send_char(CH_U, 1'b0);
        send_hex16(v);
    endtask

    function automatic logic [7:0] random_non_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
        return b;
    endfunction

    // A BMP code point outside the surrogate range, spread over run lengths.
    function automatic logic [15:0] random_bmp();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(16'h0000, 16'h007F));
            1: v = 16'($urandom_range(16'h0080, 16'h07FF));
            default: begin
                v = 16'($urandom_range(16'h0800, 16'hFFFF));
                if (v >= SURR_HI_LO && v <= SURR_LO_HI) v = v ^ 16'h4000;
            end
        endcase
        return v;
    endfunction

    function automatic logic [15:0] random_high();
        return SURR_HI_LO + 16'($urandom_range(0, 16'h3FF));
    endfunction

    function automatic logic [15:0] random_low();
        return SURR_LO_LO + 16'($urandom_range(0, 16'h3FF));
    endfunction

    // A high surrogate followed by something that breaks the pair.
    task automatic send_broken_pair();
        logic [7:0] b;
        send_u_escape(random_high());
        case ($urandom_range(0, 5))
            0: send_eot();
            1: begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
                send_char(b, 1'b0);
            end
            2: begin
                send_char(CH_BSLASH, 1'b0);
                do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                send_char(b, 1'b0);
            end
            3: send_u_escape($urandom_range(0, 1) ? random_high() : random_bmp());
            4: begin
                send_str("\\u");
                repeat ($urandom_range(0, 3))
                    send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
                send_eot();
            end
            default: begin
                send_str("\\u");
                repeat ($urandom_range(0, 3))
                    send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
                send_char(random_non_hex(), 1'b0);
            end
        endcase
    endtask

    // One piece of string content, mostly well formed.
    task automatic send_piece();
        string      letters;
        logic [7:0] b;
        int         k;
        letters = "\"\\/bfnrt";
        k = $urandom_range(0, 20);
        if (k < 8) begin
            do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
            send_char(b, 1'b0);
        end else if (k < 11) begin
            send_char(CH_BSLASH, 1'b0);
            send_char(letters[$urandom_range(0, 7)], 1'b0);
        end else if (k < 14) begin
            send_u_escape(random_bmp());
        end else if (k < 16) begin
            send_u_escape(random_high());
            send_u_escape(random_low());
        end else if (k == 16) begin
            send_char(8'($urandom_range(0, 255)), 1'b0);
        end else if (k == 17) begin
            send_char(CH_BSLASH, 1'b0);
            send_char(8'($urandom_range(0, 255)), 1'b0);
        end else if (k == 18) begin
            send_str("\\u");
            repeat ($urandom_range(0, 3))
                send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
            if ($urandom_range(0, 1)) send_eot();
            else send_char(random_non_hex(), 1'b0);
        end else if (k == 19) begin
            send_broken_pair();
        end else begin
            send_u_escape(random_low());
        end
    endtask

    // One quoted string with random content and occasional noise around it.
    task automatic send_random_string();
        case ($urandom_range(0, 9))
            0: send_char(8'($urandom_range(0, 255)), 1'b0);
            1: send_eot();
            default: ;
        endcase
        send_char(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 8)) send_piece();
        case ($urandom_range(0, 9))
            0: send_eot();
            1: ;
            default: send_char(CH_QUOTE, 1'b0);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic run_reset();
        i_rst_n   <= 1'b0;
        dec_phase = PH_IDLE;
        dec_ndig  = 2'd0;
        dec_acc   = 16'd0;
        dec_hi    = 10'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Outside a string: end of text is silent, any byte but a quote is rejected.
    task automatic test_idle_bytes();
        send_eot();
        send_char(8'hFF, 1'b0);
    endtask

    // Plain bytes at both ends of the range, control bytes and an empty string.
    task automatic test_plain_text();
        send_char(CH_QUOTE, 1'b0);
        send_char(8'h20, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h1F, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(8'h00, 1'b0);
        send_str("\"\"");
    endtask

    // All eight simple escapes, then an unknown one.
    task automatic test_simple_escapes();
        send_str("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\x");
    endtask

    // Run lengths of one, two and three bytes at their boundaries.
    task automatic test_bmp_escapes();
        send_str("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\"");
    endtask

    // Surrogate pairs at the extremes and ways a pair can go wrong.
    task automatic test_surrogate_pairs();
        send_str("\"\\uD800\\uDC00\\udbff\\uDFFF\"");
        send_str("\"\\uDC00");
        send_str("\"\\uD83D\\uD83D");
        send_str("\"\\uD800\\u0041");
        send_str("\"\\uD800x");
        send_str("\"\\uD800\\n");
        send_str("\"\\uD800\\uDC0G");
        send_str("\"\\uD800\\uDC");
        send_eot();
        send_str("\"\\uD800");
        send_eot();
    endtask

    // Text that ends inside a string, an escape or the hex digits, then a bad hex digit.
    task automatic test_truncated_text();
        send_str("\"ab");
        send_eot();
        send_str("\"\\");
        send_eot();
        send_str("\"\\u12");
        send_eot();
        send_str("\"\\u1g");
    endtask

    // The output holds off while long runs keep arriving, so the input stalls.
    task automatic test_output_backpressure();
        rx_hold_req = 1'b1;
        send_str("\"\\uD83D\\uDE00\\u20AC\\u00e9\\uFFFFend\"");
        while (rx_hold_req) @(posedge i_clk);
    endtask

    task automatic test_random_text(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) send_random_string();
    endtask

    task automatic finish_run();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && decoded_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    endtask

    initial begin
        idle_en = 1'b1;
        run_reset();
        test_idle_bytes();
        test_plain_text();
        test_simple_escapes();
        test_bmp_escapes();
        test_surrogate_pairs();
        test_truncated_text();
        test_output_backpressure();
        test_random_text(100);
        // Last stretch runs at full rate on both sides.
        idle_en = 1'b0;
        test_random_text(40);
        finish_run();
    end

endmodule
